// ----- hdl/assert_macros.svh -----
// assertion macros for the rtl files, used by the periodic minima finder
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/pmsf_pkg.sv -----
// types, constants and neighbor tables of the periodic minima finder
// no dependencies
package pmsf_pkg;

	localparam int DIV_W = 64;
	localparam int CNT_W = 7;
	localparam int PARA_STEPS = 50;
	localparam int MOD_STEPS = 32;
	localparam int CFG_DW = 24;

	localparam logic [31:0] MARK_CENTER = 32'd65536000;
	localparam logic [31:0] MARK_NEIGH = 32'd6553600;
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SCAN = 1'b1;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_WIDTH = 2'd0;
	localparam reg_idx_t REG_HEIGHT = 2'd1;
	localparam reg_idx_t REG_PITCH_X = 2'd2;
	localparam reg_idx_t REG_PITCH_Y = 2'd3;

	// point select: center, then the eight neighbors in fixed order
	typedef logic [3:0] sel_t;
	localparam sel_t SEL_CENTER = 4'd0;
	localparam sel_t SEL_LAST = 4'd8;
	localparam logic [2:0] PARA_LAST = 3'd4;

	typedef struct packed {
		logic               action;
		logic signed [31:0] sample;
	} in_t;

	typedef struct packed {
		logic        is_minimum;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic        scan_done;
		logic [16:0] minima_found;
	} out_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [1:0] {
		STEP_STAY = 2'b00,
		STEP_INC  = 2'b01,
		STEP_DEC  = 2'b11
	} step_t;

	function automatic step_t sel_dx(input sel_t sel);
		step_t s;
		case (sel)
			4'd1, 4'd2, 4'd8: s = STEP_INC;
			4'd4, 4'd5, 4'd6: s = STEP_DEC;
			default:          s = STEP_STAY;
		endcase
		return s;
	endfunction

	function automatic step_t sel_dy(input sel_t sel);
		step_t s;
		case (sel)
			4'd2, 4'd3, 4'd4: s = STEP_INC;
			4'd6, 4'd7, 4'd8: s = STEP_DEC;
			default:          s = STEP_STAY;
		endcase
		return s;
	endfunction

	// parabola samples: center, left, right, up, down
	function automatic sel_t para_sel(input logic [2:0] j);
		sel_t s;
		case (j)
			3'd1:    s = 4'd5;
			3'd2:    s = 4'd1;
			3'd3:    s = 4'd7;
			3'd4:    s = 4'd3;
			default: s = SEL_CENTER;
		endcase
		return s;
	endfunction

endpackage

// ----- hdl/pmsf_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned
// depends on pmsf_pkg; dividend comes left aligned to the step count
module pmsf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pmsf_pkg::div_req_t             req,
	input  logic [pmsf_pkg::DIV_W-1:0]     dividend,
	input  logic [pmsf_pkg::DIV_W-1:0]     divisor,
	output pmsf_pkg::div_rsp_t             rsp
);
	import pmsf_pkg::*;

	logic [DIV_W-1:0] dvd_q, dvs_q, rem_q, quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W:0]   trial, diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff = trial - {1'b0, dvs_q};
		ge = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quot_q <= {quot_q[DIV_W-2:0], ge};
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
	end

	assign rsp = '{done: done_q, quot: quot_q, rem: rem_q};

endmodule

// ----- hdl/periodic_minima_subpixel_finder.sv -----
// periodic minima finder: frame memory, scan sequencer, parabola refinement
// depends on pmsf_pkg, pmsf_div and assert_macros.svh
// a load item writes the frame memory on acceptance; a scan item runs the serial
// divider (one quotient bit per cycle) and frame memory reads, and a minimum adds
// marking and parabola refinement; items are taken one at a time; arst_n clears
// control, count and registers, not the frame memory
module periodic_minima_subpixel_finder #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pmsf_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pmsf_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  pmsf_pkg::reg_idx_t            cfg_index,
	input  logic [pmsf_pkg::CFG_DW-1:0]   cfg_data
);
	import pmsf_pkg::*;

	localparam int NW = $clog2(MAX_WIDTH + 1);
	localparam int NH = $clog2(MAX_HEIGHT + 1);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_DPOS   = 16'h0002,
		S_RD     = 16'h0004,
		S_CMP    = 16'h0008,
		S_MRD    = 16'h0010,
		S_MWR    = 16'h0020,
		S_PRD    = 16'h0040,
		S_PCAP   = 16'h0080,
		S_PPREP  = 16'h0100,
		S_PSTART = 16'h0200,
		S_PDIV   = 16'h0400,
		S_MSTART = 16'h0800,
		S_MDIV   = 16'h1000,
		S_MUL    = 16'h2000,
		S_POS    = 16'h4000,
		S_EMIT   = 16'h8000
	} state_t;

	state_t state_q;

	logic [8:0]  width_q, height_q;
	logic [23:0] pitch_x_q, pitch_y_q;

	logic [31:0]   w_sel, h_sel, size_full;
	logic [NW-1:0] w_eff;
	logic [NH-1:0] h_eff;
	logic [AW:0]   size;

	logic [AW-1:0] load_pos_q, scan_pos_q, ld_pos, sc_pos;
	logic          ld_wrap, sc_last;

	logic [XW-1:0] x_q, nx;
	logic [YW-1:0] y_q, ny;
	logic          last_q, min_q, ax_q, sneg_q;
	logic [16:0]   count_q;
	sel_t          sel_q, rsel;
	logic [2:0]    j_q;

	logic signed [31:0] c_q, rdata_q, off_q;
	logic signed [31:0] pv_q [5];
	logic signed [34:0] d_q;
	logic signed [32:0] diff_q;
	logic [31:0]        r_q, posx_q, posy_q;
	logic [55:0]        prod_q;
	out_t               out_q;
	logic               out_valid_q;

	logic               accept, ld_accept, sc_accept;
	logic [AW-1:0]      raddr, waddr;
	logic               mem_we;
	logic signed [31:0] wdata, marked, mark_k;
	logic signed [32:0] mark_t;
	logic signed [31:0] p0, p1, p2;
	logic [34:0]        d_abs;
	logic [32:0]        diff_abs;
	logic               para_neg;
	logic [DIV_W-1:0]   para_dvd, para_dvs, q, n16, idx64, s_mag;
	logic signed [DIV_W-1:0] s_val;
	logic signed [31:0] off_new;
	logic [23:0]        pitch_eff;

	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [DIV_W-1:0] div_dvd, div_dvs;

	logic signed [31:0] mem [DEPTH];

	// effective frame geometry
	always_comb begin
		if (width_q < 9'd2) w_sel = 32'd2;
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_sel = 32'(MAX_WIDTH);
		else w_sel = 32'(width_q);
		if (height_q < 9'd2) h_sel = 32'd2;
		else if (32'(height_q) > 32'(MAX_HEIGHT)) h_sel = 32'(MAX_HEIGHT);
		else h_sel = 32'(height_q);
		w_eff = NW'(w_sel);
		h_eff = NH'(h_sel);
		size_full = 32'(w_eff) * 32'(h_eff);
		size = (AW+1)'(size_full);
	end

	always_comb begin
		ld_pos = ({1'b0, load_pos_q} >= size) ? '0 : load_pos_q;
		sc_pos = ({1'b0, scan_pos_q} >= size) ? '0 : scan_pos_q;
		ld_wrap = (({1'b0, ld_pos} + 1'b1) >= size);
		sc_last = (({1'b0, sc_pos} + 1'b1) >= size);
	end

	assign accept = in_valid && in_ready;
	assign ld_accept = accept && (in_data.action == ACT_LOAD);
	assign sc_accept = accept && (in_data.action == ACT_SCAN);

	// torus-wrapped neighbor address
	always_comb begin
		rsel = (state_q == S_PRD) ? para_sel(j_q) : sel_q;
		case (sel_dx(rsel))
			STEP_INC: nx = ((32'(x_q) + 32'd1) == 32'(w_eff)) ? '0 : XW'(32'(x_q) + 32'd1);
			STEP_DEC: nx = (x_q == '0) ? XW'(32'(w_eff) - 32'd1) : XW'(32'(x_q) - 32'd1);
			default:  nx = x_q;
		endcase
		case (sel_dy(rsel))
			STEP_INC: ny = ((32'(y_q) + 32'd1) == 32'(h_eff)) ? '0 : YW'(32'(y_q) + 32'd1);
			STEP_DEC: ny = (y_q == '0) ? YW'(32'(h_eff) - 32'd1) : YW'(32'(y_q) - 32'd1);
			default:  ny = y_q;
		endcase
		raddr = AW'(32'(ny) * 32'(w_eff) + 32'(nx));
	end

	// saturating mark subtraction
	always_comb begin
		mark_k = (sel_q == SEL_CENTER) ? MARK_CENTER : MARK_NEIGH;
		mark_t = 33'(rdata_q) - 33'(mark_k);
		marked = (mark_t[32] && !mark_t[31]) ? 32'sh8000_0000 : mark_t[31:0];
		mem_we = ld_accept || (state_q == S_MWR);
		waddr = ld_accept ? ld_pos : raddr;
		wdata = ld_accept ? in_data.sample : marked;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// parabola and placement arithmetic
	always_comb begin
		p1 = pv_q[0];
		p0 = ax_q ? pv_q[3] : pv_q[1];
		p2 = ax_q ? pv_q[4] : pv_q[2];
		d_abs = d_q[34] ? 35'(-d_q) : 35'(d_q);
		diff_abs = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
		para_neg = diff_q[32] ^ d_q[34];
		para_dvd = (64'(diff_abs) << 17) + (64'(d_abs) << 1);
		para_dvs = 64'(d_abs) << 2;
		q = div_rsp.quot;
		if (para_neg) off_new = (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(32'd0 - q[31:0]);
		else off_new = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
		idx64 = ax_q ? 64'(y_q) : 64'(x_q);
		s_val = $signed(idx64 << 16) + 64'(off_q);
		s_mag = s_val[63] ? 64'(-s_val) : 64'(s_val);
		n16 = (ax_q ? 64'(h_eff) : 64'(w_eff)) << 16;
		if (ax_q) pitch_eff = (pitch_y_q == '0) ? 24'd1 : pitch_y_q;
		else pitch_eff = (pitch_x_q == '0) ? 24'd1 : pitch_x_q;
	end

	always_comb begin
		div_req = '{start: 1'b0, steps: '0};
		div_dvd = '0;
		div_dvs = '0;
		case (state_q)
			S_IDLE: if (sc_accept) begin
				div_req = '{start: 1'b1, steps: CNT_W'(AW)};
				div_dvd = 64'(sc_pos) << (DIV_W - AW);
				div_dvs = 64'(w_eff);
			end
			S_PSTART: if (d_q != '0) begin
				div_req = '{start: 1'b1, steps: CNT_W'(PARA_STEPS)};
				div_dvd = para_dvd << (DIV_W - PARA_STEPS);
				div_dvs = para_dvs;
			end
			S_MSTART: begin
				div_req = '{start: 1'b1, steps: CNT_W'(MOD_STEPS)};
				div_dvd = s_mag << (DIV_W - MOD_STEPS);
				div_dvs = n16;
			end
			default: ;
		endcase
	end

	pmsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.rsp      (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= 9'd256;
			height_q <= 9'd256;
			pitch_x_q <= 24'd65536;
			pitch_y_q <= 24'd65536;
			load_pos_q <= '0;
			scan_pos_q <= '0;
			count_q <= '0;
			x_q <= '0;
			y_q <= '0;
			last_q <= 1'b0;
			min_q <= 1'b0;
			ax_q <= 1'b0;
			sneg_q <= 1'b0;
			sel_q <= SEL_CENTER;
			j_q <= '0;
			c_q <= '0;
			pv_q <= '{default: '0};
			d_q <= '0;
			diff_q <= '0;
			off_q <= '0;
			r_q <= '0;
			prod_q <= '0;
			posx_q <= '0;
			posy_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:   width_q <= cfg_data[8:0];
					REG_HEIGHT:  height_q <= cfg_data[8:0];
					REG_PITCH_X: pitch_x_q <= cfg_data;
					REG_PITCH_Y: pitch_y_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == S_EMIT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (ld_accept) load_pos_q <= ld_wrap ? '0 : ld_pos + 1'b1;
					if (sc_accept) begin
						scan_pos_q <= sc_last ? '0 : sc_pos + 1'b1;
						last_q <= sc_last;
						min_q <= 1'b1;
						posx_q <= '0;
						posy_q <= '0;
						sel_q <= SEL_CENTER;
						if (sc_pos == '0) count_q <= '0;
						state_q <= S_DPOS;
					end
				end
				S_DPOS: if (div_rsp.done) begin
					x_q <= XW'(div_rsp.rem);
					y_q <= YW'(div_rsp.quot);
					state_q <= S_RD;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (sel_q == SEL_CENTER) c_q <= rdata_q;
					else if (rdata_q < c_q) min_q <= 1'b0;
					if (sel_q == SEL_LAST) begin
						sel_q <= SEL_CENTER;
						if (min_q && !(rdata_q < c_q)) begin
							if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
							state_q <= S_MRD;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						sel_q <= sel_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: begin
					// next read follows the write, so repeated neighbors see earlier marks
					if (sel_q == SEL_LAST) begin
						j_q <= '0;
						state_q <= S_PRD;
					end else begin
						sel_q <= sel_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				S_PRD: state_q <= S_PCAP;
				S_PCAP: begin
					pv_q[j_q] <= rdata_q;
					if (j_q == PARA_LAST) begin
						ax_q <= 1'b0;
						state_q <= S_PPREP;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_PPREP: begin
					d_q <= 35'(p0) - (35'(p1) <<< 1) + 35'(p2);
					diff_q <= 33'(p0) - 33'(p2);
					state_q <= S_PSTART;
				end
				S_PSTART: begin
					if (d_q == '0) begin
						off_q <= '0;
						state_q <= S_MSTART;
					end else begin
						state_q <= S_PDIV;
					end
				end
				S_PDIV: if (div_rsp.done) begin
					off_q <= off_new;
					state_q <= S_MSTART;
				end
				S_MSTART: begin
					sneg_q <= s_val[63];
					state_q <= S_MDIV;
				end
				S_MDIV: if (div_rsp.done) begin
					// negative positions fold back from the top of the extent
					if (sneg_q && div_rsp.rem != '0) r_q <= 32'(n16 - div_rsp.rem);
					else r_q <= div_rsp.rem[31:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= 56'(r_q) * 56'(pitch_eff);
					state_q <= S_POS;
				end
				S_POS: begin
					if (!ax_q) begin
						posx_q <= prod_q[47:16];
						ax_q <= 1'b1;
						state_q <= S_PPREP;
					end else begin
						posy_q <= prod_q[47:16];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (!out_valid_q || out_ready) begin
					out_q <= '{is_minimum: min_q, pos_x: posx_q, pos_y: posy_q,
						scan_done: last_q, minima_found: count_q};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

`include "assert_macros.svh"

	`ASSERT_IMPLY(a_mark_only_min, state_q == S_MWR, min_q, "frame marked for a non-minimum")
	`ASSERT_IMPLY(a_div_done_wait, div_rsp.done,
		state_q == S_DPOS || state_q == S_PDIV || state_q == S_MDIV, "unexpected divider result")
	`ASSERT_NEXT(a_emit_transfer, state_q == S_EMIT && (!out_valid_q || out_ready),
		out_valid_q && state_q == S_IDLE, "result not presented after emit")

endmodule

// ----- verif/pmsf_checker.sv -----
// scoreboard for the periodic minima finder: mirrors frame memory and config,
// predicts each scan result and compares it with what the block delivers
// depends on pmsf_pkg
`timescale 1ns / 100ps
module pmsf_checker #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  pmsf_pkg::in_t               in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  pmsf_pkg::out_t              out_data,
	input  logic                        cfg_we,
	input  pmsf_pkg::reg_idx_t          cfg_index,
	input  logic [pmsf_pkg::CFG_DW-1:0] cfg_data,
	output int                          errors,
	output int                          pending,
	output int                          results_seen,
	output int                          minima_seen
);
	import pmsf_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam longint CENTER_DROP = 65536000;
	localparam longint NEIGH_DROP = 6553600;
	localparam longint INT32_LOW = -64'sd2147483648;

	const int step_x[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
	const int step_y[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

	logic signed [31:0] density [DEPTH];
	int unsigned load_pos, scan_pos, min_count;
	logic [8:0] width_reg, height_reg;
	logic [23:0] pitch_x_reg, pitch_y_reg;
	out_t expected_q[$];
	int reported;

	function automatic int unsigned clamp_dim(logic [8:0] v, int unsigned hi);
		int unsigned n;
		n = v;
		if (n < 2) n = 2;
		if (n > hi) n = hi;
		return n;
	endfunction

	function automatic int unsigned torus(int unsigned v, int d, int unsigned n);
		return int'((longint'(v) + longint'(d) + longint'(n)) % longint'(n));
	endfunction

	function automatic longint peek(int unsigned x, int unsigned y, int unsigned w);
		int unsigned a;
		a = y * w + x;
		return (a < DEPTH) ? longint'(density[a]) : 0;
	endfunction

	function automatic void dent(int unsigned x, int unsigned y, int unsigned w, longint k);
		int unsigned a;
		longint t;
		a = y * w + x;
		if (a < DEPTH) begin
			t = longint'(density[a]) - k;
			if (t < INT32_LOW) t = INT32_LOW;
			density[a] = t[31:0];
		end
	endfunction

	// vertex offset of a parabola through three samples in 1/65536 of a step, rounded half away
	function automatic longint vertex_offset(longint p0, longint p1, longint p2);
		longint d, num, den2;
		longint unsigned an, ad, q;
		bit neg;
		d = p0 - 2 * p1 + p2;
		if (d == 0) return 0;
		num = (p0 - p2) * 65536;
		den2 = 2 * d;
		neg = (num < 0) != (den2 < 0);
		an = (num < 0) ? -num : num;
		ad = (den2 < 0) ? -den2 : den2;
		q = (2 * an + ad) / (2 * ad);
		if (neg) begin
			if (q > 64'd2147483648) q = 64'd2147483648;
			return -longint'(q);
		end
		if (q > 64'd2147483647) q = 64'd2147483647;
		return longint'(q);
	endfunction

	function automatic logic [31:0] wrap_position(int unsigned idx, longint off,
			logic [23:0] pitch, int unsigned n);
		longint p, prod, ext, r;
		p = (pitch == 0) ? 1 : longint'({40'd0, pitch});
		prod = (longint'(idx) * 65536 + off) * p;
		ext = longint'(n) * p * 65536;
		r = prod % ext;
		if (r < 0) r += ext;
		return r[47:16];
	endfunction

	function automatic out_t scan_pixel();
		int unsigned w, h, sz, pos, x, y;
		longint c, ox, oy;
		bit minimum;
		out_t r;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		sz = w * h;
		if (scan_pos >= sz) scan_pos = 0;
		pos = scan_pos;
		if (pos == 0) min_count = 0;
		x = pos % w;
		y = pos / w;
		c = peek(x, y, w);
		minimum = 1'b1;
		for (int n = 0; n < 8; n++)
			if (peek(torus(x, step_x[n], w), torus(y, step_y[n], h), w) < c) minimum = 1'b0;
		r = '0;
		if (minimum) begin
			dent(x, y, w, CENTER_DROP);
			for (int n = 0; n < 8; n++)
				dent(torus(x, step_x[n], w), torus(y, step_y[n], h), w, NEIGH_DROP);
			ox = vertex_offset(peek(torus(x, -1, w), y, w), peek(x, y, w),
				peek(torus(x, 1, w), y, w));
			oy = vertex_offset(peek(x, torus(y, -1, h), w), peek(x, y, w),
				peek(x, torus(y, 1, h), w));
			r.pos_x = wrap_position(x, ox, pitch_x_reg, w);
			r.pos_y = wrap_position(y, oy, pitch_y_reg, h);
			if (min_count < 131071) min_count++;
		end
		r.is_minimum = minimum;
		r.scan_done = (pos + 1 >= sz);
		r.minima_found = min_count[16:0];
		scan_pos = (pos + 1 >= sz) ? 0 : pos + 1;
		return r;
	endfunction

	function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			if (reported < 10) begin
				reported++;
				$display("mismatch on result %0d, %s: expected %h, got %h",
					results_seen, name, exp_v, act_v);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned sz;
		out_t e;
		if (!arst_n) begin
			load_pos = 0;
			scan_pos = 0;
			min_count = 0;
			width_reg = 9'd256;
			height_reg = 9'd256;
			pitch_x_reg = 24'd65536;
			pitch_y_reg = 24'd65536;
			expected_q.delete();
			errors = 0;
			reported = 0;
			pending = 0;
			results_seen = 0;
			minima_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:   width_reg = cfg_data[8:0];
					REG_HEIGHT:  height_reg = cfg_data[8:0];
					REG_PITCH_X: pitch_x_reg = cfg_data;
					REG_PITCH_Y: pitch_y_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.action == ACT_LOAD) begin
					sz = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
					if (load_pos >= sz) load_pos = 0;
					if (load_pos < DEPTH) density[load_pos] = in_data.sample;
					load_pos = (load_pos + 1 >= sz) ? 0 : load_pos + 1;
				end else begin
					expected_q.push_back(scan_pixel());
				end
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result: %p", out_data);
					end
				end else begin
					e = expected_q.pop_front();
					field_check("is_minimum", e.is_minimum, out_data.is_minimum);
					field_check("pos_x", e.pos_x, out_data.pos_x);
					field_check("pos_y", e.pos_y, out_data.pos_y);
					field_check("scan_done", e.scan_done, out_data.scan_done);
					field_check("minima_found", e.minima_found, out_data.minima_found);
					if (e.is_minimum) minima_seen++;
				end
				results_seen++;
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// top of the periodic minima finder testbench: clock, reset, frame loads, scans,
// register writes and handshake pressure; depends on pmsf_pkg and pmsf_checker
`timescale 1ns / 100ps
module tb;
	import pmsf_pkg::*;

	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_ITEMS = 50;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	in_t in_data;
	out_t out_data;
	reg_idx_t cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	int errors, pending, results_seen, minima_seen;
	int cycles = 0;
	int loads = 0, scans = 0, setups = 0, rand_items = 0;
	int frame_cells;
	bit burst_tx = 0, burst_rx = 0;
	int rx_hold = 0;

	periodic_minima_subpixel_finder uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pmsf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending),
		.results_seen(results_seen), .minima_seen(minima_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: random stall per result, plus one long hold when requested
	initial begin
		int stall;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = burst_rx ? 0 : $urandom_range(0, 10);
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// called at a falling edge; valid stays up when the next transfer follows at once
	task automatic push_item(logic act, logic [31:0] s);
		int gap;
		gap = burst_tx ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{action: act, sample: s};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (act == ACT_LOAD) loads++;
		else scans++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(logic [8:0] w, logic [8:0] h, logic [23:0] px, logic [23:0] py);
		logic [CFG_DW-1:0] vals[4];
		int cw, ch;
		vals[0] = {15'($urandom), w};
		vals[1] = {15'($urandom), h};
		vals[2] = px;
		vals[3] = py;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cw = (w < 2) ? 2 : (w > 256) ? 256 : w;
		ch = (h < 2) ? 2 : (h > 256) ? 256 : h;
		frame_cells = cw * ch;
		setups++;
	endtask

	function automatic logic [31:0] density_value(int kind);
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000 + $urandom_range(0, 32'h0800_0000);
			default: ;
		endcase
		if (kind == 1) return $urandom;
		// few distinct levels so ties and minima show up often
		return ($urandom_range(0, 12) << 15) - 32'h0004_0000 + $urandom_range(0, 3);
	endfunction

	task automatic run_frame(logic [8:0] w, logic [8:0] h, logic [23:0] px, logic [23:0] py,
			int nscan, int kind, bit hold);
		settle();
		configure(w, h, px, py);
		burst_tx = ($urandom_range(0, 3) == 0);
		burst_rx = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < frame_cells; i++) push_item(ACT_LOAD, density_value(kind));
		if (hold) rx_hold = 2000;
		for (int i = 0; i < nscan; i++) begin
			if ($urandom_range(0, 9) == 0) push_item(ACT_LOAD, density_value(kind));
			else push_item(ACT_SCAN, $urandom);
		end
	endtask

	function automatic logic [23:0] pick_pitch();
		case ($urandom_range(0, 4))
			0: return 24'd0;
			1: return 24'd1;
			2: return 24'hff_ffff;
			3: return 24'd65536;
			default: return $urandom_range(1, 24'hff_ffff);
		endcase
	endfunction

	initial begin
		logic [31:0] edge_samples[9];
		logic [8:0] w, h;
		int before_count;
		edge_samples = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000,
			32'h7fff_ffff, 32'h8000_0001, 32'h5, 32'hfffe_0000};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		frame_cells = 65536;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 3x3 frame with extreme samples, zero pitch on y
		configure(9'd3, 9'd3, 24'd65536, 24'd0);
		foreach (edge_samples[i]) push_item(ACT_LOAD, edge_samples[i]);
		repeat (9) push_item(ACT_SCAN, 32'h0);
		// flat 2x2 frame from out of range sizes: repeated neighbors, zero denominators
		settle();
		configure(9'd1, 9'd0, 24'd1, 24'hff_ffff);
		repeat (4) push_item(ACT_LOAD, 32'h0);
		repeat (4) push_item(ACT_SCAN, 32'hffff_ffff);

		// widest and tallest frames, positions past 32 bits
		run_frame(9'd511, 9'd2, 24'hff_ffff, 24'd1, 24, 0, 0);
		run_frame(9'd2, 9'd300, 24'd3, 24'hff_ffff, 24, 0, 0);

		while (rand_items < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
			before_count = loads + scans;
			run_frame(w, h, pick_pitch(), pick_pitch(), 0, 0, 0);
			run_frame(w, h, pick_pitch(), pick_pitch(),
				$urandom_range(frame_cells, 3 * frame_cells), $urandom_range(0, 1),
				rand_items == 0);
			rand_items += loads + scans - before_count;
		end

		settle();
		$display("covered %0d loads and %0d scans over %0d register setups", loads, scans, setups);
		$display("%0d results checked, %0d of them minima", results_seen, minima_seen);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
